/* sv/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, defaults and counter helpers for the tournament predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  typedef logic [1:0] ctr_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  localparam int PC_INDEX_BITS_DEF    = 10;
  localparam int LOCAL_HIST_BITS_DEF  = 10;
  localparam int GLOBAL_HIST_BITS_DEF = 9;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_TRAIN   = 1'b1;

  localparam ctr_t CTR_MIN  = 2'd0;
  localparam ctr_t CTR_INIT = 2'd1;
  localparam ctr_t CTR_MAX  = 2'd3;

  // saturating step toward up or down
  function automatic ctr_t ctr_bump(input ctr_t ctr, input logic up);
    ctr_t res;
    if (up) begin
      res = (ctr == CTR_MAX) ? CTR_MAX : ctr_t'(ctr + 2'd1);
    end else begin
      res = (ctr == CTR_MIN) ? CTR_MIN : ctr_t'(ctr - 2'd1);
    end
    return res;
  endfunction

  // upper half predicts taken; for the chooser, upper half picks local
  function automatic logic ctr_high(input ctr_t ctr);
    return ctr[1];
  endfunction

endpackage

`default_nettype wire

/* sv/tournament_branch_predictor.sv */
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// An accepted input beat passes through the stage 1 and stage 2 registers into the
// output register; throughput one beat per cycle, limited by the output stall and the
// clearing pass. Forwarding of the last history and counter writes keeps back-to-back
// trains exact. After reset a clearing pass writes every table, one index a cycle,
// over 2^max(PC_INDEX_BITS, LOCAL_HIST_BITS, GLOBAL_HIST_BITS) indices (1024 by
// default) with in_stall high.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_branch_predictor #(
  parameter int PC_INDEX_BITS    = tbp_pkg::PC_INDEX_BITS_DEF,
  parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
  parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [31:0] in_pc,
  input  wire logic        in_outcome,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_prediction
);

  localparam int PC_ENTRIES = 1 << PC_INDEX_BITS;
  localparam int LH_ENTRIES = 1 << LOCAL_HIST_BITS;
  localparam int GH_ENTRIES = 1 << GLOBAL_HIST_BITS;
  localparam int CLR_BITS_A = (PC_INDEX_BITS > LOCAL_HIST_BITS) ? PC_INDEX_BITS
                                                                : LOCAL_HIST_BITS;
  localparam int CLR_BITS   = (CLR_BITS_A > GLOBAL_HIST_BITS) ? CLR_BITS_A
                                                              : GLOBAL_HIST_BITS;

  // tables
  logic [LOCAL_HIST_BITS-1:0] lht_mem [PC_ENTRIES];
  tbp_pkg::ctr_t              lc_mem  [LH_ENTRIES];
  tbp_pkg::ctr_t              gc_mem  [GH_ENTRIES];
  tbp_pkg::ctr_t              cc_mem  [GH_ENTRIES];

  // control
  tbp_pkg::state_t       state_r, state_nxt;
  logic                  clearing;
  logic [CLR_BITS-1:0]   clr_idx_r;
  logic                  advance;
  logic                  accept;

  // global history
  logic [GLOBAL_HIST_BITS-1:0] ghist_r;
  logic [GLOBAL_HIST_BITS:0]   ghist_shift;
  logic [GLOBAL_HIST_BITS-1:0] ghist_nxt;

  // stage 1
  logic                        s1_valid_r;
  logic                        s1_train_r;
  logic                        s1_outcome_r;
  logic [PC_INDEX_BITS-1:0]    s1_slot_r;
  logic [GLOBAL_HIST_BITS-1:0] s1_gidx_r;
  logic [LOCAL_HIST_BITS-1:0]  lht_rd_r;
  logic [LOCAL_HIST_BITS-1:0]  s1_lhist;
  logic [LOCAL_HIST_BITS:0]    s1_lhist_shift;
  logic                        s1_wr;

  // last history write
  logic                        lf_valid_r;
  logic [PC_INDEX_BITS-1:0]    lf_slot_r;
  logic [LOCAL_HIST_BITS-1:0]  lf_data_r;

  // stage 2
  logic                        s2_valid_r;
  logic                        s2_train_r;
  logic                        s2_outcome_r;
  logic [LOCAL_HIST_BITS-1:0]  s2_lhist_r;
  logic [GLOBAL_HIST_BITS-1:0] s2_gidx_r;
  tbp_pkg::ctr_t               lc_rd_r;
  tbp_pkg::ctr_t               gc_rd_r;
  tbp_pkg::ctr_t               cc_rd_r;
  tbp_pkg::ctr_t               s2_lc;
  tbp_pkg::ctr_t               s2_gc;
  tbp_pkg::ctr_t               s2_cc;
  tbp_pkg::ctr_t               lc_upd;
  tbp_pkg::ctr_t               gc_upd;
  tbp_pkg::ctr_t               cc_upd;
  logic                        local_pred;
  logic                        global_pred;
  logic                        pred;
  logic                        s2_wr;

  // last counter write
  logic                        fw_valid_r;
  logic [LOCAL_HIST_BITS-1:0]  fw_lhist_r;
  logic [GLOBAL_HIST_BITS-1:0] fw_gidx_r;
  tbp_pkg::ctr_t               fw_lc_r;
  tbp_pkg::ctr_t               fw_gc_r;
  tbp_pkg::ctr_t               fw_cc_r;

  // output register
  logic                        out_valid_r;
  logic                        out_prediction_r;

  // write ports
  logic                        lht_we;
  logic [PC_INDEX_BITS-1:0]    lht_waddr;
  logic [LOCAL_HIST_BITS-1:0]  lht_wdata;
  logic                        ctr_we;
  logic [LOCAL_HIST_BITS-1:0]  lc_waddr;
  logic [GLOBAL_HIST_BITS-1:0] gc_waddr;
  tbp_pkg::ctr_t               lc_wdata;
  tbp_pkg::ctr_t               gc_wdata;
  tbp_pkg::ctr_t               cc_wdata;

  // clearing sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbp_pkg::ST_CLEAR: begin
        if (&clr_idx_r) begin
          state_nxt = tbp_pkg::ST_RUN;
        end
      end
      tbp_pkg::ST_RUN: begin
        state_nxt = tbp_pkg::ST_RUN;
      end
      default: begin
        state_nxt = tbp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      tbp_pkg::ST_CLEAR: clearing = 1'b1;
      tbp_pkg::ST_RUN:   clearing = 1'b0;
      default:           clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tbp_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_idx_r <= CLR_BITS'(clr_idx_r + 1'b1);
      end
    end
  end

  // handshake
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = clearing || !advance;
  assign accept   = in_valid && !in_stall;

  assign ghist_shift = {ghist_r, in_outcome};
  assign ghist_nxt   = ghist_shift[GLOBAL_HIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ghist_r <= '0;
    end else if (accept && in_command == tbp_pkg::CMD_TRAIN) begin
      ghist_r <= ghist_nxt;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_train_r   <= (in_command == tbp_pkg::CMD_TRAIN);
      s1_outcome_r <= in_outcome;
      s1_slot_r    <= in_pc[PC_INDEX_BITS-1:0];
      s1_gidx_r    <= ghist_r;
      lht_rd_r     <= lht_mem[in_pc[PC_INDEX_BITS-1:0]];
    end
  end

  // stage 1: local history with bypass of the write at the same edge
  assign s1_lhist = (lf_valid_r && lf_slot_r == s1_slot_r) ? lf_data_r : lht_rd_r;
  assign s1_lhist_shift = {s1_lhist, s1_outcome_r};
  assign s1_wr = advance && s1_valid_r && s1_train_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_valid_r <= 1'b0;
    end else if (advance) begin
      lf_valid_r <= s1_valid_r && s1_train_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lf_slot_r <= s1_slot_r;
      lf_data_r <= s1_lhist_shift[LOCAL_HIST_BITS-1:0];
    end
  end

  assign lht_we    = clearing || s1_wr;
  assign lht_waddr = clearing ? clr_idx_r[PC_INDEX_BITS-1:0] : s1_slot_r;
  assign lht_wdata = clearing ? '0 : s1_lhist_shift[LOCAL_HIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (lht_we) begin
      lht_mem[lht_waddr] <= lht_wdata;
    end
  end

  // stage 2 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_train_r   <= s1_train_r;
      s2_outcome_r <= s1_outcome_r;
      s2_lhist_r   <= s1_lhist;
      s2_gidx_r    <= s1_gidx_r;
      lc_rd_r      <= lc_mem[s1_lhist];
      gc_rd_r      <= gc_mem[s1_gidx_r];
      cc_rd_r      <= cc_mem[s1_gidx_r];
    end
  end

  // stage 2: counters with bypass, prediction and update
  assign s2_lc = (fw_valid_r && fw_lhist_r == s2_lhist_r) ? fw_lc_r : lc_rd_r;
  assign s2_gc = (fw_valid_r && fw_gidx_r == s2_gidx_r) ? fw_gc_r : gc_rd_r;
  assign s2_cc = (fw_valid_r && fw_gidx_r == s2_gidx_r) ? fw_cc_r : cc_rd_r;

  assign local_pred  = tbp_pkg::ctr_high(s2_lc);
  assign global_pred = tbp_pkg::ctr_high(s2_gc);
  assign pred        = tbp_pkg::ctr_high(s2_cc) ? local_pred : global_pred;

  assign lc_upd = tbp_pkg::ctr_bump(s2_lc, s2_outcome_r);
  assign gc_upd = tbp_pkg::ctr_bump(s2_gc, s2_outcome_r);
  assign cc_upd = (local_pred != global_pred)
                ? tbp_pkg::ctr_bump(s2_cc, local_pred == s2_outcome_r)
                : s2_cc;

  assign s2_wr = advance && s2_valid_r && s2_train_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else if (advance) begin
      fw_valid_r <= s2_valid_r && s2_train_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fw_lhist_r <= s2_lhist_r;
      fw_gidx_r  <= s2_gidx_r;
      fw_lc_r    <= lc_upd;
      fw_gc_r    <= gc_upd;
      fw_cc_r    <= cc_upd;
    end
  end

  assign ctr_we   = clearing || s2_wr;
  assign lc_waddr = clearing ? clr_idx_r[LOCAL_HIST_BITS-1:0] : s2_lhist_r;
  assign gc_waddr = clearing ? clr_idx_r[GLOBAL_HIST_BITS-1:0] : s2_gidx_r;
  assign lc_wdata = clearing ? tbp_pkg::CTR_INIT : lc_upd;
  assign gc_wdata = clearing ? tbp_pkg::CTR_INIT : gc_upd;
  assign cc_wdata = clearing ? tbp_pkg::CTR_INIT : cc_upd;

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      lc_mem[lc_waddr] <= lc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_we) begin
      gc_mem[gc_waddr] <= gc_wdata;
      cc_mem[gc_waddr] <= cc_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_prediction_r <= pred;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prediction = out_prediction_r;

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted beat missing from stage 1");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!s1_valid_r && !s2_valid_r && !out_valid_r))
    else $error("pipeline busy during clearing pass");

  a_ghist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && in_command == tbp_pkg::CMD_TRAIN) |=> $stable(ghist_r))
    else $error("global history moved without a train beat");

  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_valid_r) |=> out_valid_r)
    else $error("stage 2 beat lost before output");

endmodule

`default_nettype wire
